/* rtl/cfrag_pkg.sv */
// Shared types and constants of the CAN command fragmenter.
package cfrag_pkg;

    localparam int unsigned PAYLOAD_MAX = 7;

    localparam logic [7:0] NODE_ADDR_A = 8'd5;
    localparam logic [7:0] NODE_ADDR_B = 8'd6;
    localparam logic [7:0] POS_ADDR    = 8'd0;
    localparam logic [7:0] POS_FUNC    = 8'd1;
    localparam logic [7:0] POS_MAX     = 8'd255;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic                        kind;
        logic [10:0]                 can_id;
        logic [3:0]                  frame_length;
        t_byte                       byte0;
        logic [PAYLOAD_MAX-1:0][7:0] payload;
        logic                        final_frame;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/cfrag_if.sv */
// Handshake interfaces for command beats in and CAN frame results out.
interface cfrag_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfrag_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] can_id;
    logic [3:0]  frame_length;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic        final_frame;

    modport source (
        output valid, output kind, output can_id, output frame_length, output byte0,
        output byte1, output byte2, output byte3, output byte4, output byte5,
        output byte6, output byte7, output final_frame, input ready
    );
    modport sink (
        input valid, input kind, input can_id, input frame_length, input byte0,
        input byte1, input byte2, input byte3, input byte4, input byte5,
        input byte6, input byte7, input final_frame, output ready
    );
endinterface

/* rtl/can_command_fragmenter_top.sv */
// Top level of the CAN command fragmenter: front end, result queue and output stage.
//
// The block takes a motor command one byte per beat on i_cmd, with last_byte set on
// the final beat. The first byte is the node address (5 or 6), the second the function
// code, and the rest payload. Every seven payload bytes, and at the last byte, it sends
// one standard-ID CAN frame on o_frame: can_id is address times 256 plus a running
// frame number, byte0 the function code, then the payload with unused bytes zero, and
// frame_length the payload count plus one. A bad address, a command of fewer than
// three bytes or one of more than 255 bytes ends in a single error beat (kind set,
// all else zero, final_frame set); frames already sent stand. The input takes one
// beat per clock cycle for as long as the result queue has room. A beat that makes a
// result writes it into the queue at its accepting edge; the output register loads it
// from the queue when that register is empty or taken, and then offers it on o_frame.
// The queue holds QUEUE_DEPTH results; only when it and the output register are both
// full, because the receiver holds ready low, does i_cmd.ready drop.
module can_command_fragmenter_top
    import cfrag_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfrag_in_if.sink    i_cmd,
    cfrag_out_if.source o_frame
);

    t_push     push;
    t_q_status q_status;
    t_result   q_item;
    logic      pop;

    // Parses beats, keeps per-command state and forms each result in the cycle of its beat.
    cfrag_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_q_status (q_status),
        .o_push     (push)
    );

    // Decouples parsing from the receiver so each side can stall on its own.
    cfrag_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status),
        .o_item   (q_item)
    );

    // Registered output beat, refilled from the queue whenever it is empty or taken.
    cfrag_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_frame    (o_frame)
    );

endmodule

/* rtl/cfrag_front.sv */
// Front end: takes command beats, gathers payload and builds frame or error results.
module cfrag_front
    import cfrag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfrag_in_if.sink   i_cmd,
    input  t_q_status  i_q_status,
    output t_push      o_push
);

    t_byte       r_addr, n_addr;
    t_byte       r_func, n_func;
    t_byte       r_store [PAYLOAD_MAX];
    t_byte       n_store [PAYLOAD_MAX];
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_pos, n_pos;
    logic [5:0]  r_fnum, n_fnum;
    logic        r_reject, n_reject;

    logic        accept;
    logic        gathered;
    t_push       push;

    assign i_cmd.ready = !i_q_status.full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_push      = push;

    always_comb begin
        n_addr   = r_addr;
        n_func   = r_func;
        n_store  = r_store;
        n_count  = r_count;
        n_pos    = r_pos;
        n_fnum   = r_fnum;
        n_reject = r_reject;
        gathered = 1'b0;
        push     = '0;

        if (accept) begin
            if (r_pos == POS_MAX) begin
                n_reject = 1'b1;
            end else if (r_pos == POS_ADDR) begin
                n_addr = i_cmd.data_byte;
                if (i_cmd.data_byte != NODE_ADDR_A && i_cmd.data_byte != NODE_ADDR_B) begin
                    n_reject = 1'b1;
                end
            end else if (r_pos == POS_FUNC) begin
                n_func = i_cmd.data_byte;
            end else if (!r_reject) begin
                if (r_count < 3'(PAYLOAD_MAX)) begin
                    n_store[r_count] = i_cmd.data_byte;
                    n_count          = r_count + 3'd1;
                end
                gathered = 1'b1;
            end

            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 8'd1;
            end

            if (gathered && (n_count == 3'(PAYLOAD_MAX) || i_cmd.last_byte)) begin
                // Only addresses five and six reach here, so the low three bits suffice.
                push.valid             = 1'b1;
                push.item.kind         = KIND_FRAME;
                push.item.can_id       = {n_addr[2:0], 2'b00, r_fnum};
                push.item.frame_length = {1'b0, n_count} + 4'd1;
                push.item.byte0        = n_func;
                for (int k = 0; k < PAYLOAD_MAX; k++) begin
                    push.item.payload[k] = (3'(k) < n_count) ? n_store[k] : 8'd0;
                end
                push.item.final_frame  = i_cmd.last_byte;
                n_count = '0;
                n_fnum  = r_fnum + 6'd1;
            end else if (i_cmd.last_byte) begin
                push.valid            = 1'b1;
                push.item.kind        = KIND_ERROR;
                push.item.final_frame = 1'b1;
            end

            if (i_cmd.last_byte) begin
                n_addr   = '0;
                n_func   = '0;
                n_count  = '0;
                n_pos    = '0;
                n_fnum   = '0;
                n_reject = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_func   <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_fnum   <= '0;
            r_reject <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_func   <= n_func;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_fnum   <= n_fnum;
            r_reject <= n_reject;
        end
    end

    // Payload bytes are only read below the fill count, so they need no reset.
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

endmodule

/* rtl/cfrag_queue.sv */
// Small result queue between the front end and the output stage.
module cfrag_queue
    import cfrag_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_result   o_item
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result       r_entry [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_entry[r_rd_ptr];
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

/* rtl/cfrag_back.sv */
// Output stage: drains the result queue into a registered output beat.
module cfrag_back
    import cfrag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_result     i_item,
    output logic        o_pop,
    cfrag_out_if.source o_frame
);

    logic    r_valid;
    t_result r_item;

    assign o_pop = !i_q_status.empty && (!r_valid || o_frame.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_frame.valid        = r_valid;
    assign o_frame.kind         = r_item.kind;
    assign o_frame.can_id       = r_item.can_id;
    assign o_frame.frame_length = r_item.frame_length;
    assign o_frame.byte0        = r_item.byte0;
    assign o_frame.byte1        = r_item.payload[0];
    assign o_frame.byte2        = r_item.payload[1];
    assign o_frame.byte3        = r_item.payload[2];
    assign o_frame.byte4        = r_item.payload[3];
    assign o_frame.byte5        = r_item.payload[4];
    assign o_frame.byte6        = r_item.payload[5];
    assign o_frame.byte7        = r_item.payload[6];
    assign o_frame.final_frame  = r_item.final_frame;

endmodule
